@@ rtl/tensor_index_permute_top_defines.svh @@
// Assertion macros for the tensor index permute RTL.
`ifndef TENSOR_INDEX_PERMUTE_TOP_DEFINES_SVH
`define TENSOR_INDEX_PERMUTE_TOP_DEFINES_SVH

// Same-cycle implication, checked on aclk outside reset.
`define TIP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on aclk outside reset.
`define TIP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/tip_pkg.sv @@
// Package: types, constants and helpers for the tensor index permute block.
package tip_pkg;

    localparam int CNT_W             = 13;
    localparam int POS_W             = 12;
    localparam int WORD_W            = 64;
    localparam int CFG_IDX_W         = 2;
    localparam int COUNT_LIMIT       = 4096;
    localparam int MAX_ELEMS_DEFAULT = 4096;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_INNER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MOVED = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GROUP = 2'd2;

    // Item kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [WORD_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              last;
        logic              overflow;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SIZE,
        ST_ADDR,
        ST_DECIDE,
        ST_READ
    } state_t;

    // Clamp a count register into 1..COUNT_LIMIT.
    function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = CNT_W'(1);
        end else if (v > CNT_W'(COUNT_LIMIT)) begin
            r = CNT_W'(COUNT_LIMIT);
        end
        return r;
    endfunction

endpackage

@@ rtl/tensor_index_permute_top.sv @@
// Top level: batch buffer that permutes [group][moved][inner] words to [moved][group][inner].
// Steps: accept, size, address, decide; a load is written in decide. A drain reads the RAM
//   in decide and fills the output register in a read state that waits until it frees up.
// Flow: s_ready is high only in idle, so no new item is taken until the last one is done;
//   the address is built by two registered multiplies and one RAM port.
// Reset (aresetn low, synchronous): counters, overflow flag and counts (to 1) clear;
//   buffer contents are kept and need no clearing pass.
module tensor_index_permute_top #(
    parameter int MAX_ELEMS = tip_pkg::MAX_ELEMS_DEFAULT
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // configuration write port
    input  logic                                  cfg_wr_en,
    input  logic [tip_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [tip_pkg::CNT_W-1:0]             cfg_wdata,
    // input channel
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  tip_pkg::in_item_t                     s_item,
    // result channel
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output tip_pkg::out_item_t                    m_item
);

    localparam int CNT_W  = tip_pkg::CNT_W;
    localparam int POS_W  = tip_pkg::POS_W;
    localparam int AW     = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
    localparam int LCW    = $clog2(MAX_ELEMS + 1);
    localparam int PROD_W = 2 * CNT_W;            // inner * moved
    localparam int TOT_W  = 3 * CNT_W;            // whole batch size
    localparam int GM_W   = POS_W + CNT_W;        // group_pos * moved
    localparam int ROW_W  = GM_W + 1 + CNT_W;     // (gm + moved_pos) * inner
    localparam int ADDR_W = ROW_W + 1;            // plus inner_pos

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] inner_cnt_reg, moved_cnt_reg, group_cnt_reg;
    logic [CNT_W-1:0] ni, nm, ng;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inner_cnt_reg <= CNT_W'(1);
            moved_cnt_reg <= CNT_W'(1);
            group_cnt_reg <= CNT_W'(1);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                tip_pkg::REG_INNER: inner_cnt_reg <= cfg_wdata;
                tip_pkg::REG_MOVED: moved_cnt_reg <= cfg_wdata;
                tip_pkg::REG_GROUP: group_cnt_reg <= cfg_wdata;
                default: ;  // unmapped index: drop the write
            endcase
        end
    end

    // Zero counts as one, anything past the limit saturates.
    assign ni = tip_pkg::eff_count(inner_cnt_reg);
    assign nm = tip_pkg::eff_count(moved_cnt_reg);
    assign ng = tip_pkg::eff_count(group_cnt_reg);

    // ------------------------------------------------------------------
    // Control and datapath registers
    // ------------------------------------------------------------------
    tip_pkg::state_t    state_reg, state_next;
    tip_pkg::in_item_t  item_reg, item_next;
    tip_pkg::out_item_t out_reg, out_next;
    logic               out_valid_reg, out_valid_next;

    logic [LCW-1:0]     load_count_reg, load_count_next;
    logic [POS_W-1:0]   inner_pos_reg, inner_pos_next;
    logic [POS_W-1:0]   group_pos_reg, group_pos_next;
    logic [POS_W-1:0]   moved_pos_reg, moved_pos_next;
    logic               overflow_flag_reg, overflow_flag_next;

    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [GM_W-1:0]    gm_reg, gm_next;
    logic [LCW-1:0]     cap_reg, cap_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic               addr_ok_reg, addr_ok_next;
    logic               last_pend_reg, last_pend_next;

    logic [TOT_W-1:0]   total;
    logic [ADDR_W-1:0]  addr;
    logic               inner_wrap, group_wrap, moved_wrap;

    // RAM strobes and read data
    logic               mem_we;
    logic               mem_re;
    logic [tip_pkg::WORD_W-1:0] rdata_reg;

    // Full batch size; only its clamp to the buffer depth is kept.
    assign total = TOT_W'(prod_reg) * TOT_W'(ng);
    assign addr  = ADDR_W'(row_reg) + ADDR_W'(inner_pos_reg);

    // Walk counter carries: a counter at or past its last position (count - 1) wraps to zero.
    assign inner_wrap = ({1'b0, inner_pos_reg} + CNT_W'(1)) >= ni;
    assign group_wrap = ({1'b0, group_pos_reg} + CNT_W'(1)) >= ng;
    assign moved_wrap = ({1'b0, moved_pos_reg} + CNT_W'(1)) >= nm;

    always_comb begin
        state_next         = state_reg;
        item_next          = item_reg;
        out_next           = out_reg;
        out_valid_next     = out_valid_reg && !m_ready;   // drop on transfer
        load_count_next    = load_count_reg;
        inner_pos_next     = inner_pos_reg;
        group_pos_next     = group_pos_reg;
        moved_pos_next     = moved_pos_reg;
        overflow_flag_next = overflow_flag_reg;
        prod_next          = prod_reg;
        gm_next            = gm_reg;
        cap_next           = cap_reg;
        row_next           = row_reg;
        addr_ok_next       = addr_ok_reg;
        last_pend_next     = last_pend_reg;
        mem_we             = 1'b0;
        mem_re             = 1'b0;
        s_ready            = 1'b0;

        case (state_reg)
            tip_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    item_next  = s_item;
                    state_next = tip_pkg::ST_SIZE;
                end
            end

            // First multiply stage: slab size and group row base.
            tip_pkg::ST_SIZE: begin
                prod_next  = PROD_W'(ni) * PROD_W'(nm);
                gm_next    = GM_W'(group_pos_reg) * GM_W'(nm);
                state_next = tip_pkg::ST_ADDR;
            end

            // Second multiply stage: batch capacity and word row address.
            tip_pkg::ST_ADDR: begin
                if (total >= TOT_W'(MAX_ELEMS)) begin
                    cap_next = LCW'(MAX_ELEMS);
                end else begin
                    cap_next = total[LCW-1:0];
                end
                row_next   = (ROW_W'(gm_reg) + ROW_W'(moved_pos_reg)) * ROW_W'(ni);
                state_next = tip_pkg::ST_DECIDE;
            end

            tip_pkg::ST_DECIDE: begin
                state_next = tip_pkg::ST_IDLE;
                if (item_reg.kind == tip_pkg::KIND_LOAD) begin
                    if (load_count_reg >= cap_reg) begin
                        overflow_flag_next = 1'b1;
                    end else begin
                        mem_we          = 1'b1;
                        load_count_next = load_count_reg + LCW'(1);
                    end
                end else if (load_count_reg >= cap_reg) begin
                    // Batch complete: read the word if its address is in range, and advance the walk.
                    addr_ok_next   = addr < ADDR_W'(MAX_ELEMS);
                    mem_re         = addr < ADDR_W'(MAX_ELEMS);
                    last_pend_next = inner_wrap && group_wrap && moved_wrap;
                    if (inner_wrap) begin
                        inner_pos_next = '0;
                        if (group_wrap) begin
                            group_pos_next = '0;
                            if (moved_wrap) begin
                                moved_pos_next = '0;
                            end else begin
                                moved_pos_next = moved_pos_reg + POS_W'(1);
                            end
                        end else begin
                            group_pos_next = group_pos_reg + POS_W'(1);
                        end
                    end else begin
                        inner_pos_next = inner_pos_reg + POS_W'(1);
                    end
                    if (inner_wrap && group_wrap && moved_wrap) begin
                        load_count_next = '0;
                    end
                    state_next = tip_pkg::ST_READ;
                end
            end

            // Hold the read word until the output register frees up.
            tip_pkg::ST_READ: begin
                if (!out_valid_reg || m_ready) begin
                    out_next.word     = addr_ok_reg ? rdata_reg : '0;
                    out_next.last     = last_pend_reg;
                    out_next.overflow = overflow_flag_reg;
                    out_valid_next    = 1'b1;
                    state_next        = tip_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = tip_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= tip_pkg::ST_IDLE;
            out_valid_reg     <= 1'b0;
            load_count_reg    <= '0;
            inner_pos_reg     <= '0;
            group_pos_reg     <= '0;
            moved_pos_reg     <= '0;
            overflow_flag_reg <= 1'b0;
        end else begin
            state_reg         <= state_next;
            out_valid_reg     <= out_valid_next;
            load_count_reg    <= load_count_next;
            inner_pos_reg     <= inner_pos_next;
            group_pos_reg     <= group_pos_next;
            moved_pos_reg     <= moved_pos_next;
            overflow_flag_reg <= overflow_flag_next;
        end
    end

    // Payload and pipeline registers carry no reset.
    always_ff @(posedge aclk) begin
        item_reg      <= item_next;
        out_reg       <= out_next;
        prod_reg      <= prod_next;
        gm_reg        <= gm_next;
        cap_reg       <= cap_next;
        row_reg       <= row_next;
        addr_ok_reg   <= addr_ok_next;
        last_pend_reg <= last_pend_next;
    end

    // ------------------------------------------------------------------
    // Word buffer: one write port, one registered read port. A load and a
    // drain never share a cycle, so no forwarding is needed.
    // ------------------------------------------------------------------
    logic [tip_pkg::WORD_W-1:0] word_mem [MAX_ELEMS];

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            word_mem[load_count_reg[AW-1:0]] <= item_reg.value;
        end
        if (mem_re) begin
            rdata_reg <= word_mem[addr[AW-1:0]];
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`include "tensor_index_permute_top_defines.svh"

    `TIP_ASSERT_NEXT(a_overflow_sticky, overflow_flag_reg, overflow_flag_reg, "flag cleared")
    `TIP_ASSERT_NOW(a_load_in_range, 1'b1, load_count_reg <= LCW'(MAX_ELEMS), "count past depth")
    `TIP_ASSERT_NOW(a_write_in_range, mem_we, load_count_reg < cap_reg, "write past capacity")
    `TIP_ASSERT_NEXT(a_read_follows_decide, mem_re, state_reg == tip_pkg::ST_READ, "no read state")

endmodule

@@ test/tensor_index_permute_top_test.sv @@
// Self-checking testbench for the tensor index permute block: directed batches, then random ones.
module tensor_index_permute_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tip_pkg::*;

    // Run with the shipping store depth so the clamp to the store is the real one.
    localparam int STORE_DEPTH   = MAX_ELEMS_DEFAULT;
    // Random share of the item budget; the directed tests take the rest.
    localparam int RANDOM_ITEMS  = 950;
    // Longest quiet stretch of a correct run is the forced receiver hold plus a
    // drain latency; allow several times that.
    localparam int STALL_LIMIT   = 3000;
    localparam int RX_HOLD_LEN   = 400;
    // A load keeps the block busy until its decide state and yields no word; wait past that.
    localparam int SETTLE_CYCLES = 8;
    localparam int REPORT_LIMIT  = 10;
    // Index with no register behind it; a write there must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY} rx_mode_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CNT_W-1:0]     cfg_wdata;
    logic                 s_valid;
    logic                 s_ready;
    in_item_t             s_item;
    logic                 m_valid;
    logic                 m_ready;
    out_item_t            m_item;

    tensor_index_permute_top #(
        .MAX_ELEMS(STORE_DEPTH)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the block: buffer, fill level, walk position, flag
    // and the three count registers (raw, as written).
    // ------------------------------------------------------------------
    logic [WORD_W-1:0] shadow_store [STORE_DEPTH];
    int unsigned       words_held    = 0;
    int unsigned       inner_at      = 0;
    int unsigned       group_at      = 0;
    int unsigned       moved_at      = 0;
    bit                overflow_seen = 1'b0;
    logic [CNT_W-1:0]  inner_reg     = CNT_W'(1);
    logic [CNT_W-1:0]  moved_reg     = CNT_W'(1);
    logic [CNT_W-1:0]  group_reg     = CNT_W'(1);

    out_item_t expected_words[$];
    int        fail_count  = 0;
    int        items_sent  = 0;
    int        quiet_cycles = 0;

    // Sender burst state and receiver stall state.
    bit       tx_gaps_on    = 1'b1;
    int       burst_left    = 0;
    int       rx_hold_left  = 0;
    int       rx_phase_left = 0;
    rx_mode_t rx_style      = RX_OPEN;

    // 10 ns clock.
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // A register of 0 acts as 1, anything past the limit acts as the limit.
    function automatic longint unsigned clamp_count(input logic [CNT_W-1:0] raw);
        if (raw == '0) return 1;
        if (raw > COUNT_LIMIT) return COUNT_LIMIT;
        return raw;
    endfunction

    // Words the buffer takes before drains are honored.
    function automatic longint unsigned batch_capacity();
        longint unsigned total;
        total = clamp_count(inner_reg) * clamp_count(moved_reg) * clamp_count(group_reg);
        return (total < STORE_DEPTH) ? total : STORE_DEPTH;
    endfunction

    // Advance one walk counter; a counter at or past span - 1 wraps with a carry.
    function automatic bit walk_step(inout int unsigned pos, input longint unsigned span);
        if (pos + 1 >= span) begin
            pos = 0;
            return 1'b1;
        end
        pos++;
        return 1'b0;
    endfunction

    // Apply one accepted item to the shadow state; queue the word a drain yields.
    function automatic void permute_step(input in_item_t it);
        longint unsigned ni, nm, ng, addr;
        out_item_t       res;
        ni = clamp_count(inner_reg);
        nm = clamp_count(moved_reg);
        ng = clamp_count(group_reg);
        if (it.kind == KIND_LOAD) begin
            // Drop loads past the capacity and latch the flag for good.
            if (words_held >= batch_capacity()) begin
                overflow_seen = 1'b1;
            end else begin
                shadow_store[words_held] = it.value;
                words_held++;
            end
            return;
        end
        // Ignore a drain until the batch is fully loaded.
        if (words_held < batch_capacity()) return;
        addr = (group_at * nm + moved_at) * ni + inner_at;
        res.word = (addr < STORE_DEPTH) ? shadow_store[addr] : '0;
        // Inner fastest, then group, then moved; the carry out of moved ends the batch.
        res.last = walk_step(inner_at, ni) && walk_step(group_at, ng) &&
                   walk_step(moved_at, nm);
        // The walk counters have all wrapped to zero already.
        if (res.last) words_held = 0;
        res.overflow = overflow_seen;
        expected_words.push_back(res);
    endfunction

    // Loads still needed before drains start producing words.
    function automatic int unsigned loads_missing();
        longint unsigned cap;
        cap = batch_capacity();
        return (words_held < cap) ? int'(cap - words_held) : 0;
    endfunction

    // Drains from the current walk position up to and including the last word.
    function automatic int unsigned drains_left();
        int unsigned     i, g, m, n;
        longint unsigned ni, nm, ng;
        bit              wrapped;
        i  = inner_at;
        g  = group_at;
        m  = moved_at;
        n  = 0;
        ni = clamp_count(inner_reg);
        nm = clamp_count(moved_reg);
        ng = clamp_count(group_reg);
        do begin
            n++;
            wrapped = walk_step(i, ni) && walk_step(g, ng) && walk_step(m, nm);
        end while (!wrapped);
        return n;
    endfunction

    function automatic logic [WORD_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Mostly small counts, now and then a zero register.
    function automatic logic [CNT_W-1:0] pick_count(input int unsigned top);
        if ($urandom_range(0, 11) == 0) return '0;
        return CNT_W'($urandom_range(1, top));
    endfunction

    // ------------------------------------------------------------------
    // Monitor: track register writes and input transfers in the shadow
    // model, and check every result transfer against the oldest word
    // waiting. Everything is sampled at the rising edge.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : result_monitor
        out_item_t want;
        if (aresetn) begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_INNER: inner_reg = cfg_wdata;
                    REG_MOVED: moved_reg = cfg_wdata;
                    REG_GROUP: group_reg = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) permute_step(s_item);
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT) begin
                        $display("%0t: unexpected word %h last=%0b overflow=%0b",
                                 $realtime, m_item.word, m_item.last, m_item.overflow);
                    end
                end else begin
                    want = expected_words.pop_front();
                    if (m_item.word !== want.word || m_item.last !== want.last ||
                        m_item.overflow !== want.overflow) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT) begin
                            $display("%0t: expected %h last=%0b ovf=%0b, got %h last=%0b ovf=%0b",
                                     $realtime, want.word, want.last, want.overflow,
                                     m_item.word, m_item.last, m_item.overflow);
                        end
                    end
                end
            end
        end
    end

    // Watchdog: end the run once nothing has moved for too long.
    always @(posedge aclk) begin
        if (!aresetn || cfg_wr_en || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver: a forced hold when a test asks for one, else phases of
    // random length that are always ready, lightly stalled or heavily stalled.
    always @(negedge aclk) begin
        if (rx_hold_left > 0) begin
            m_ready <= 1'b0;
            rx_hold_left--;
        end else begin
            if (rx_phase_left == 0) begin
                rx_phase_left = $urandom_range(16, 160);
                rx_style      = rx_mode_t'($urandom_range(0, 2));
            end
            rx_phase_left--;
            case (rx_style)
                RX_OPEN:  m_ready <= 1'b1;
                RX_LIGHT: m_ready <= ($urandom_range(0, 3) != 0);
                default:  m_ready <= $urandom_range(0, 1);
            endcase
        end
    end

    // Offer one item and return at the edge that accepts it. A burst of
    // random length runs back to back; most bursts open after a short gap.
    task automatic send_item(input in_item_t it);
        int gap;
        gap = 0;
        if (tx_gaps_on) begin
            if (burst_left <= 0) begin
                burst_left = $urandom_range(1, 40);
                if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 9);
            end
            burst_left--;
        end
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_item  <= it;
        items_sent++;
        do begin
            @(posedge aclk);
        end while (!s_ready);
    endtask

    task automatic send_load(input logic [WORD_W-1:0] value);
        in_item_t it;
        it.kind  = KIND_LOAD;
        it.value = value;
        send_item(it);
    endtask

    // The value of a drain is junk on purpose; the block must not use it.
    task automatic send_drain();
        in_item_t it;
        it.kind  = KIND_DRAIN;
        it.value = rand_word();
        send_item(it);
    endtask

    // Random loads, with stray early drains mixed in when noisy.
    task automatic send_loads(input int unsigned n, input bit noisy);
        repeat (n) begin
            if (noisy && $urandom_range(0, 7) == 0) send_drain();
            send_load(rand_word());
        end
    endtask

    task automatic send_drains(input int unsigned n);
        repeat (n) send_drain();
    endtask

    // Drop valid, let every expected word come out, then let the last load finish.
    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
    endtask

    // Reshape only while the block is idle.
    task automatic set_counts(input logic [CNT_W-1:0] ni, nm, ng);
        wait_idle();
        cfg_write(REG_INNER, ni);
        cfg_write(REG_MOVED, nm);
        cfg_write(REG_GROUP, ng);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Complete the batch in flight from the idle shadow state: fill it,
    // maybe push a few loads past the end, then walk it to the last word.
    task automatic finish_batch(input bit noisy);
        int unsigned walk_len;
        wait_idle();
        walk_len = drains_left();
        send_loads(loads_missing(), noisy);
        if (noisy && $urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 2)) send_load(rand_word());
        end
        send_drains(walk_len);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Counts are 1 after reset, so every batch is a single word.
    task automatic test_reset_batch();
        send_drain();                       // nothing loaded: ignored
        send_load('1);
        send_drain();
        send_load('0);
        send_drain();
        send_load(64'h8000_0000_0000_0001);
        send_drain();
        send_drain();                       // batch already done: ignored
    endtask

    // Zero registers clamp to 1; a write to the spare index is ignored.
    task automatic test_zero_counts();
        set_counts('0, '0, '0);
        cfg_write(REG_SPARE, '1);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        send_load(64'h7FFF_FFFF_FFFF_FFFE);
        send_drain();
    endtask

    // Plain transpose with inner span 1, then a shape with real inner runs.
    task automatic test_transpose();
        set_counts(13'd1, 13'd3, 13'd2);
        for (int k = 0; k < 6; k++) send_load(64'hF0F0_0000_0000_0000 | 64'(k));
        send_drains(6);
        set_counts(13'd2, 13'd2, 13'd3);
        finish_batch(1'b0);
    endtask

    // Walk a tall batch partway, then reshape it wide: the moved position
    // left behind puts every remaining read past the store, and each comes
    // back as zero. The tall batch also fills the low store entries that
    // random reshapes revisit.
    task automatic test_past_store();
        set_counts(13'd1, 13'd150, 13'd1);
        send_loads(150, 1'b0);
        send_drains(64);
        set_counts(13'd65, 13'd1, 13'd1);
        finish_batch(1'b0);
    endtask

    // Change counts partway through a drain walk.
    task automatic test_count_change();
        // Shrink inner to no more than the current inner position: wraps with a carry.
        set_counts(13'd2, 13'd3, 13'd2);
        send_loads(12, 1'b0);
        send_drains(5);
        set_counts(13'd1, 13'd3, 13'd2);
        finish_batch(1'b0);
        // Grow the batch: drains are ignored until the extra words are loaded.
        set_counts(13'd2, 13'd2, 13'd2);
        send_loads(8, 1'b0);
        send_drains(3);
        set_counts(13'd2, 13'd2, 13'd3);
        send_drain();
        finish_batch(1'b0);
        // Shrink moved and group under a partly walked batch.
        set_counts(13'd3, 13'd3, 13'd3);
        send_loads(27, 1'b0);
        send_drains(20);
        set_counts(13'd3, 13'd2, 13'd1);
        finish_batch(1'b0);
    endtask

    // Hold the result side for a long stretch while drains keep coming,
    // so the block backs up and stalls its input.
    task automatic test_output_stall();
        set_counts(13'd4, 13'd4, 13'd2);
        send_loads(32, 1'b0);
        wait_idle();
        @(posedge aclk);
        rx_hold_left = RX_HOLD_LEN;
        tx_gaps_on   = 1'b0;
        send_drains(32);
        tx_gaps_on   = 1'b1;
    endtask

    // A load past a full batch is dropped and latches the flag for good.
    task automatic test_load_overflow();
        set_counts(13'd1, 13'd2, 13'd1);
        send_load('1);
        send_drain();                       // one word short: ignored
        send_load('0);
        send_load(64'hA5A5_5A5A_A5A5_5A5A);   // dropped
        send_drains(2);
        finish_batch(1'b0);                 // flag stays set
    endtask

    // Well-formed batches of random shape and content with stray drains,
    // extra loads and the odd reshape partway through a walk.
    task automatic test_random_batches();
        int          base;
        int unsigned walk_len;
        base = items_sent;
        while (items_sent - base < RANDOM_ITEMS) begin
            set_counts(pick_count(4), pick_count(6), pick_count(6));
            if ($urandom_range(0, 5) == 0) begin
                walk_len = drains_left();
                send_loads(loads_missing(), 1'b1);
                send_drains($urandom_range(0, walk_len - 1));
                set_counts(pick_count(4), pick_count(6), pick_count(6));
            end
            finish_batch(1'b1);
        end
    endtask

    initial begin
        // Drive every input to a known value, hold reset, then release it.
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid   = 1'b0;
        s_item    = '0;
        m_ready   = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_batch();
        test_zero_counts();
        test_transpose();
        test_past_store();
        test_count_change();
        test_output_stall();
        test_load_overflow();
        test_random_batches();

        // Let the pipeline drain, then give any stray word time to show up.
        wait_idle();
        repeat (4 * SETTLE_CYCLES) @(posedge aclk);
        fail_count += expected_words.size();
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/tip_pkg.sv
rtl/tensor_index_permute_top.sv
test/tensor_index_permute_top_test.sv
